// ----- hw/rtl/framed_value_stack_defines.svh -----
// Assertion helpers for the framed value stack
`ifndef FRAMED_VALUE_STACK_DEFINES_SVH
`define FRAMED_VALUE_STACK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define FVS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fvs_pkg.sv -----
package fvs_pkg;

    typedef enum logic [2:0] {
        OP_PUSH       = 3'd0,
        OP_POP        = 3'd1,
        OP_PEEK       = 3'd2,
        OP_READ_AT    = 3'd3,
        OP_WRITE_AT   = 3'd4,
        OP_PUSH_FRAME = 3'd5,
        OP_POP_FRAME  = 3'd6,
        OP_NOP        = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_UNDERFLOW       = 3'd1,
        ST_RANGE           = 3'd2,
        ST_FRAME_UNDERFLOW = 3'd3,
        ST_FULL            = 3'd4,
        ST_FRAME_FULL      = 3'd5
    } status_t;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        op_t               op;
        logic signed [6:0] position;
        logic [63:0]       value;
    } cmd_t;

endpackage

// ----- hw/rtl/fvs_front.sv -----
module fvs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           opcode,
    input  logic signed [6:0]    position,
    input  logic [63:0]          write_value,
    output fvs_pkg::cmd_t        cmd,
    output logic                 q_valid,
    input  logic                 q_ready
);
    import fvs_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              cmd_in;
    logic              push, pop;

    always_comb
    begin
        cmd_in.op       = op_t'(opcode);
        cmd_in.position = position;
        cmd_in.value    = write_value;
    end

    assign in_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign cmd      = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ----- hw/rtl/fvs_back.sv -----
module fvs_back #(
    parameter int STACK_DEPTH = 64,
    parameter int FRAME_DEPTH = 8,
    parameter int VALUE_WIDTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  fvs_pkg::cmd_t   cmd,
    input  logic            q_valid,
    output logic            q_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [63:0]     read_value,
    output logic [2:0]      status,
    output logic [6:0]      frame_size,
    output logic [3:0]      frame_level
);
    import fvs_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(FRAME_DEPTH + 1);
    localparam int FW = $clog2(FRAME_DEPTH);
    localparam int EW = ((CW > 7) ? CW : 7) + 1;

    typedef enum logic {S_EXEC, S_FIN} state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   base_reg, base_next;
    logic [LW-1:0]   level_reg, level_next;
    status_t         pend_status_reg, pend_status_next;
    logic            pend_rd_reg, pend_rd_next;
    logic            pend_base_reg, pend_base_next;
    logic            pend_zero_reg, pend_zero_next;
    logic            out_valid_reg, out_valid_next;
    logic [63:0]     read_value_reg, read_value_next;
    status_t         status_reg, status_next;
    logic [6:0]      frame_size_reg, frame_size_next;
    logic [3:0]      frame_level_reg, frame_level_next;

    logic [VALUE_WIDTH-1:0] value_mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] value_q;
    logic [CW-1:0]          base_mem [FRAME_DEPTH];
    logic [CW-1:0]          base_q;

    logic            mem_we, mem_re, fb_we, fb_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [FW-1:0]   fb_waddr, fb_raddr;
    logic [EW-1:0]   top_e, base_e, size_e, at_e, mag_e, pos_e;
    logic [7:0]      neg8;
    logic            in_range, exec, out_free;
    logic [CW-1:0]   top_m1, base_new;
    logic [LW-1:0]   level_m2;

    assign exec     = (state_reg == S_EXEC) && q_valid;
    assign q_ready  = (state_reg == S_EXEC);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        top_e  = EW'(count_reg);
        base_e = EW'(base_reg);
        size_e = top_e - base_e;
        neg8   = ~{cmd.position[6], cmd.position} + 8'd1;
        mag_e  = EW'(neg8);
        pos_e  = EW'(cmd.position[5:0]);
        if (!cmd.position[6])
        begin
            at_e     = base_e + pos_e;
            in_range = (at_e < top_e);
        end
        else
        begin
            at_e     = top_e - mag_e;
            in_range = (mag_e <= size_e);
        end
        top_m1   = count_reg - CW'(1);
        level_m2 = level_reg - LW'(2);
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        base_next        = base_reg;
        level_next       = level_reg;
        pend_status_next = pend_status_reg;
        pend_rd_next     = pend_rd_reg;
        pend_base_next   = pend_base_reg;
        pend_zero_next   = pend_zero_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        read_value_next  = read_value_reg;
        status_next      = status_reg;
        frame_size_next  = frame_size_reg;
        frame_level_next = frame_level_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        fb_we            = 1'b0;
        fb_re            = 1'b0;
        mem_waddr        = count_reg[AW-1:0];
        mem_raddr        = top_m1[AW-1:0];
        fb_waddr         = level_reg[FW-1:0];
        fb_raddr         = level_m2[FW-1:0];
        base_new         = base_reg;

        case (state_reg)
            S_EXEC:
            begin
                if (exec)
                begin
                    pend_status_next = ST_OK;
                    pend_rd_next     = 1'b0;
                    pend_base_next   = 1'b0;
                    pend_zero_next   = 1'b0;
                    state_next       = S_FIN;
                    case (cmd.op)
                        OP_PUSH:
                        begin
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                pend_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (count_reg <= base_reg)
                            begin
                                pend_status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                mem_re       = 1'b1;
                                pend_rd_next = 1'b1;
                                if (cmd.op == OP_POP)
                                begin
                                    count_next = top_m1;
                                end
                            end
                        end
                        OP_READ_AT:
                        begin
                            mem_raddr = at_e[AW-1:0];
                            if (in_range)
                            begin
                                mem_re       = 1'b1;
                                pend_rd_next = 1'b1;
                            end
                            else
                            begin
                                pend_status_next = ST_RANGE;
                            end
                        end
                        OP_WRITE_AT:
                        begin
                            mem_waddr = at_e[AW-1:0];
                            if (in_range)
                            begin
                                mem_we = 1'b1;
                            end
                            else
                            begin
                                pend_status_next = ST_RANGE;
                            end
                        end
                        OP_PUSH_FRAME:
                        begin
                            if (level_reg == LW'(FRAME_DEPTH))
                            begin
                                pend_status_next = ST_FRAME_FULL;
                            end
                            else
                            begin
                                fb_we      = 1'b1;
                                level_next = level_reg + LW'(1);
                                base_next  = count_reg;
                            end
                        end
                        OP_POP_FRAME:
                        begin
                            if (level_reg <= LW'(1))
                            begin
                                pend_status_next = ST_FRAME_UNDERFLOW;
                            end
                            else
                            begin
                                fb_re          = 1'b1;
                                count_next     = base_reg;
                                level_next     = level_reg - LW'(1);
                                pend_base_next = 1'b1;
                                pend_zero_next = (level_reg == LW'(2));
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    if (pend_base_reg)
                    begin
                        base_new = pend_zero_reg ? '0 : base_q;
                    end
                    base_next        = base_new;
                    out_valid_next   = 1'b1;
                    read_value_next  = pend_rd_reg ? 64'(value_q) : 64'd0;
                    status_next      = pend_status_reg;
                    frame_size_next  = 7'(count_reg - base_new);
                    frame_level_next = 4'(level_reg);
                    state_next       = S_EXEC;
                end
            end
            default:
            begin
                state_next = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_EXEC;
            count_reg       <= '0;
            base_reg        <= '0;
            level_reg       <= LW'(1);
            pend_status_reg <= ST_OK;
            pend_rd_reg     <= 1'b0;
            pend_base_reg   <= 1'b0;
            pend_zero_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            base_reg        <= base_next;
            level_reg       <= level_next;
            pend_status_reg <= pend_status_next;
            pend_rd_reg     <= pend_rd_next;
            pend_base_reg   <= pend_base_next;
            pend_zero_reg   <= pend_zero_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg  <= read_value_next;
        status_reg      <= status_next;
        frame_size_reg  <= frame_size_next;
        frame_level_reg <= frame_level_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            value_mem[mem_waddr] <= cmd.value[VALUE_WIDTH-1:0];
        end
        if (mem_re)
        begin
            value_q <= value_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fb_we)
        begin
            base_mem[fb_waddr] <= count_reg;
        end
        if (fb_re)
        begin
            base_q <= base_mem[fb_raddr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign frame_size  = frame_size_reg;
    assign frame_level = frame_level_reg;

endmodule

// ----- hw/rtl/framed_value_stack.sv -----
// Channel   Handshake              Payload
// request   in_valid / in_ready    opcode, position, write_value
// result    out_valid / out_ready  read_value, status, frame_size, frame_level
//
// A request enters a two-entry queue, and the executor takes it from the head.
// In S_EXEC the executor checks a request and issues the value and frame-base
// memory accesses; in S_FIN, once the result slot is free, the registered read
// data and the status are registered as the result. The executor takes no new
// request until the last result is registered. Reset clears the counts and
// the frame base and sets the frame level to 1; both memories stay unwritten.
// A stalled result holds the executor; the queue takes requests until full.
module framed_value_stack #(
    parameter int STACK_DEPTH = 64,
    parameter int FRAME_DEPTH = 8,
    parameter int VALUE_WIDTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        opcode,
    input  logic signed [6:0] position,
    input  logic [63:0]       write_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [63:0]       read_value,
    output logic [2:0]        status,
    output logic [6:0]        frame_size,
    output logic [3:0]        frame_level
);
    import fvs_pkg::*;

    `include "framed_value_stack_defines.svh"

    cmd_t cmd;
    logic q_valid;
    logic q_ready;

    fvs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .position    (position),
        .write_value (write_value),
        .cmd         (cmd),
        .q_valid     (q_valid),
        .q_ready     (q_ready)
    );

    fvs_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAME_DEPTH (FRAME_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .status      (status),
        .frame_size  (frame_size),
        .frame_level (frame_level)
    );

    `FVS_ASSERT_NEXT(a_accept_fills_queue, clk, rst_n, in_valid && in_ready, q_valid, "accepted request missing from queue")
    `FVS_ASSERT_SAME(a_error_reads_zero, clk, rst_n, out_valid && (status != ST_OK), read_value == 64'd0, "failed request returned data")
    `FVS_ASSERT_SAME(a_base_frame_only, clk, rst_n, out_valid && (status == ST_FRAME_UNDERFLOW), frame_level == 4'd1, "frame underflow with frames open")

endmodule
